// ----- design/bsss_pkg.sv -----
// Package of the broadcast step slice scheduler: field widths, role and
// register codes, and the ring add/subtract used by the shared unit.
// No dependencies.
package bsss_pkg;

    // Field widths
    localparam int IDX_W      = 7;   // rank and slice indices
    localparam int RANK_W     = 8;   // rank count
    localparam int STEP_W     = 3;   // step number and step count
    localparam int CNT_W      = 7;   // slice count
    localparam int NUM_W      = 6;   // slice number
    localparam int ROLE_W     = 2;
    localparam int CFG_W      = 8;   // widest register
    localparam int CFG_ADDR_W = 2;

    localparam int MAX_RANKS_DEFAULT = 128;
    localparam int MAX_SLICES        = 64;

    // Role codes
    typedef enum logic [ROLE_W-1:0] {
        ROLE_IDLE = 2'd0,
        ROLE_SEND = 2'd1,
        ROLE_RECV = 2'd2,
        ROLE_BOTH = 2'd3
    } role_t;

    // Register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RANK_COUNT = 2'd0,
        REG_MY_INDEX   = 2'd1,
        REG_ROOT_INDEX = 2'd2,
        REG_STEP_COUNT = 2'd3
    } cfg_addr_t;

    // Phase codes
    localparam logic ACT_SCATTER   = 1'b0;
    localparam logic ACT_ALLGATHER = 1'b1;

    // Add or subtract on the ring of r ranks; both operands are below r.
    function automatic logic [IDX_W-1:0] ring_op(
        input logic [IDX_W-1:0]  a,
        input logic [IDX_W-1:0]  b,
        input logic              sub,
        input logic [RANK_W-1:0] r
    );
        logic [RANK_W-1:0] t;
        if (sub) begin
            if (a >= b) begin
                t = {1'b0, a} - {1'b0, b};
            end else begin
                t = {1'b0, a} + r - {1'b0, b};
            end
        end else begin
            t = {1'b0, a} + {1'b0, b};
            if (t >= r) begin
                t = t - r;
            end
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

// ----- design/broadcast_step_slice_schedule_core.sv -----
// Top level of the broadcast step slice scheduler: configuration registers,
// setup sequencer and slice emitter around a shared ring add/subtract unit.
// Depends on bsss_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  s_      | in        | s_valid / s_ready  | s_action, s_step
//  m_      | out       | m_valid / m_ready  | role, peers, slices, count, number, last
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wdata
//
// An item runs through setup: a check, then e doublings of the peer delta modulo
// the rank count (e = exponent of the step, up to 6), then stride, distance, role
// on scatter only, and peers; a bad item or a zero slice count goes straight to
// the idle word. Then come up to 64 result words, and the sequencer goes idle.
// s_ready is high only while the sequencer is idle; the last word of an item
// may still wait in the output register while the next item is taken.
// A stalled output holds the emitter. Reset is synchronous, active low, and
// brings the registers to rank_count 2, my_index 0, root_index 0, step_count 1.
module broadcast_step_slice_schedule_core
    import bsss_pkg::*;
#(
    parameter int MAX_RANKS = MAX_RANKS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [STEP_W-1:0]     s_step,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROLE_W-1:0]     m_role,
    output logic [IDX_W-1:0]      m_send_peer,
    output logic [IDX_W-1:0]      m_recv_peer,
    output logic [IDX_W-1:0]      m_tx_slice,
    output logic [IDX_W-1:0]      m_rx_slice,
    output logic [CNT_W-1:0]      m_slice_count,
    output logic [NUM_W-1:0]      m_slice_number,
    output logic                  m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_POW,
        ST_STRIDE,
        ST_DIST,
        ST_ROLE,
        ST_PEER,
        ST_EMIT
    } state_t;

    // Configuration registers
    logic [RANK_W-1:0] rank_count_reg;
    logic [IDX_W-1:0]  my_index_reg;
    logic [IDX_W-1:0]  root_index_reg;
    logic [STEP_W-1:0] step_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_count_reg <= RANK_W'(2);
            my_index_reg   <= '0;
            root_index_reg <= '0;
            step_count_reg <= STEP_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RANK_COUNT: rank_count_reg <= cfg_wdata;
                REG_MY_INDEX:   my_index_reg   <= cfg_wdata[IDX_W-1:0];
                REG_ROOT_INDEX: root_index_reg <= cfg_wdata[IDX_W-1:0];
                REG_STEP_COUNT: step_count_reg <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers
    state_t            state_reg;
    logic              act_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] exp_reg;
    logic [STEP_W-1:0] iter_reg;
    logic [IDX_W-1:0]  pm_reg;      // peer delta mod r
    logic [IDX_W-1:0]  stride_reg;
    logic [IDX_W-1:0]  dr_reg;
    role_t             role_reg;
    logic [IDX_W-1:0]  speer_reg;
    logic [IDX_W-1:0]  rpeer_reg;
    logic [IDX_W-1:0]  tx_reg;
    logic [IDX_W-1:0]  rx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  idx_reg;

    // Output register
    logic              m_valid_reg;
    role_t             m_role_reg;
    logic [IDX_W-1:0]  m_send_peer_reg;
    logic [IDX_W-1:0]  m_recv_peer_reg;
    logic [IDX_W-1:0]  m_tx_slice_reg;
    logic [IDX_W-1:0]  m_rx_slice_reg;
    logic [CNT_W-1:0]  m_slice_count_reg;
    logic [NUM_W-1:0]  m_slice_number_reg;
    logic              m_last_reg;

    // Effective rank count, saturated
    logic [RANK_W-1:0] rank_eff;
    assign rank_eff = (rank_count_reg > RANK_W'(MAX_RANKS)) ? RANK_W'(MAX_RANKS)
                                                            : rank_count_reg;

    // Checks and slice count, worked out in the check cycle
    logic              bad_item;
    logic [STEP_W-1:0] exp_next;
    logic [RANK_W-1:0] pow_next;
    logic [RANK_W:0]   cnt_sum;
    logic [RANK_W:0]   cnt_shift;
    logic [CNT_W-1:0]  cnt_next;

    always_comb begin
        bad_item = (rank_count_reg < RANK_W'(2))
                || ({1'b0, my_index_reg} >= rank_eff)
                || (step_reg >= step_count_reg)
                || ((act_reg == ACT_SCATTER) && ({1'b0, root_index_reg} >= rank_eff));
        exp_next  = (act_reg == ACT_ALLGATHER) ? (step_count_reg - STEP_W'(1) - step_reg)
                                               : step_reg;
        pow_next  = RANK_W'(1) << exp_next;
        cnt_sum   = {1'b0, rank_eff} - (RANK_W+1)'(1) + {1'b0, pow_next};
        cnt_shift = (cnt_sum >> exp_next) >> 1;
        cnt_next  = (cnt_shift > (RANK_W+1)'(MAX_SLICES)) ? CNT_W'(MAX_SLICES)
                                                          : cnt_shift[CNT_W-1:0];
    end

    // Scatter span on the step of this item
    logic              rank_pow2;
    logic              last_step;
    logic [RANK_W-1:0] pow_cur;
    logic [RANK_W-1:0] span;
    logic [RANK_W:0]   span_end;

    always_comb begin
        rank_pow2 = (rank_eff & (rank_eff - RANK_W'(1))) == '0;
        last_step = (step_reg == step_count_reg - STEP_W'(1));
        pow_cur   = RANK_W'(1) << exp_reg;
        if (!rank_pow2 && last_step) begin
            span = (rank_eff > pow_cur) ? (rank_eff - pow_cur) : '0;
        end else begin
            span = pow_cur;
        end
        span_end = {1'b0, span} + {1'b0, pow_cur};
    end

    // Shared ring unit, two lanes: setup uses lane A (and B for the second
    // peer), the emitter steps tx on A and rx on B.
    logic [IDX_W-1:0] lane_a_op_a, lane_a_op_b, lane_a_res;
    logic             lane_a_sub;
    logic [IDX_W-1:0] lane_b_op_a, lane_b_op_b, lane_b_res;

    always_comb begin
        lane_a_op_a = pm_reg;
        lane_a_op_b = pm_reg;
        lane_a_sub  = 1'b0;
        unique case (state_reg)
            ST_DIST: begin
                lane_a_op_a = root_index_reg;
                lane_a_op_b = my_index_reg;
                lane_a_sub  = 1'b1;
            end
            ST_PEER: begin
                lane_a_op_a = my_index_reg;
                lane_a_sub  = (role_reg == ROLE_SEND);
            end
            ST_EMIT: begin
                lane_a_op_a = tx_reg;
                lane_a_op_b = stride_reg;
                lane_a_sub  = 1'b1;
            end
            default: ;
        endcase
        lane_b_op_a = (state_reg == ST_EMIT) ? rx_reg : my_index_reg;
        lane_b_op_b = (state_reg == ST_EMIT) ? stride_reg : pm_reg;
        lane_a_res  = ring_op(lane_a_op_a, lane_a_op_b, lane_a_sub, rank_eff);
        lane_b_res  = ring_op(lane_b_op_a, lane_b_op_b, 1'b1, rank_eff);
    end

    logic out_free;
    logic idx_last;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_last = ({1'b0, idx_reg} + CNT_W'(1)) == cnt_reg;

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // output valid: set when the emitter loads a word, cleared when taken
            if ((state_reg == ST_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_action;
                        step_reg  <= s_step;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    exp_reg  <= exp_next;
                    iter_reg <= exp_next;
                    cnt_reg  <= cnt_next;
                    pm_reg   <= IDX_W'(1);
                    role_reg <= ROLE_IDLE;
                    if (bad_item || cnt_next == '0) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_POW;
                    end
                end
                ST_POW: begin
                    // doubling modulo r, once per unit of the exponent
                    if (iter_reg == '0) begin
                        state_reg <= ST_STRIDE;
                    end else begin
                        pm_reg   <= lane_a_res;
                        iter_reg <= iter_reg - STEP_W'(1);
                    end
                end
                ST_STRIDE: begin
                    stride_reg <= lane_a_res;
                    state_reg  <= ST_DIST;
                end
                ST_DIST: begin
                    if (act_reg == ACT_ALLGATHER) begin
                        role_reg  <= ROLE_BOTH;
                        state_reg <= ST_PEER;
                    end else begin
                        dr_reg    <= lane_a_res;
                        state_reg <= ST_ROLE;
                    end
                end
                ST_ROLE: begin
                    // nothing to do leaves role idle, and the emitter sends the idle word
                    if ({1'b0, dr_reg} < span) begin
                        role_reg  <= ROLE_SEND;
                        state_reg <= ST_PEER;
                    end else if (({1'b0, dr_reg} >= pow_cur)
                              && ({2'b0, dr_reg} < span_end)) begin
                        role_reg  <= ROLE_RECV;
                        state_reg <= ST_PEER;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_PEER: begin
                    idx_reg <= '0;
                    unique case (role_reg)
                        ROLE_SEND: begin
                            speer_reg <= lane_a_res;
                            tx_reg    <= lane_a_res;
                            rpeer_reg <= '0;
                            rx_reg    <= '0;
                        end
                        ROLE_RECV: begin
                            rpeer_reg <= lane_a_res;
                            rx_reg    <= my_index_reg;
                            speer_reg <= '0;
                            tx_reg    <= '0;
                        end
                        default: begin
                            speer_reg <= lane_a_res;
                            tx_reg    <= my_index_reg;
                            rpeer_reg <= lane_b_res;
                            rx_reg    <= lane_b_res;
                        end
                    endcase
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (role_reg == ROLE_IDLE) begin
                            // idle word: all zero, marked last
                            m_role_reg         <= ROLE_IDLE;
                            m_send_peer_reg    <= '0;
                            m_recv_peer_reg    <= '0;
                            m_tx_slice_reg     <= '0;
                            m_rx_slice_reg     <= '0;
                            m_slice_count_reg  <= '0;
                            m_slice_number_reg <= '0;
                            m_last_reg         <= 1'b1;
                            state_reg          <= ST_IDLE;
                        end else begin
                            m_role_reg         <= role_reg;
                            m_send_peer_reg    <= speer_reg;
                            m_recv_peer_reg    <= rpeer_reg;
                            m_tx_slice_reg     <= role_reg[0] ? tx_reg : '0;
                            m_rx_slice_reg     <= role_reg[1] ? rx_reg : '0;
                            m_slice_count_reg  <= cnt_reg;
                            m_slice_number_reg <= idx_reg;
                            m_last_reg         <= idx_last;
                            tx_reg             <= lane_a_res;
                            rx_reg             <= lane_b_res;
                            idx_reg            <= idx_reg + NUM_W'(1);
                            if (idx_last) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_role         = m_role_reg;
    assign m_send_peer    = m_send_peer_reg;
    assign m_recv_peer    = m_recv_peer_reg;
    assign m_tx_slice     = m_tx_slice_reg;
    assign m_rx_slice     = m_rx_slice_reg;
    assign m_slice_count  = m_slice_count_reg;
    assign m_slice_number = m_slice_number_reg;
    assign m_last         = m_last_reg;

endmodule

// ----- design/bsss_checker.sv -----
// Port-level checks for the broadcast step slice scheduler, and the bind
// that attaches them to the top level. Depends on bsss_pkg.
module bsss_checker
    import bsss_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [ROLE_W-1:0]     m_role,
    input logic [IDX_W-1:0]      m_send_peer,
    input logic [IDX_W-1:0]      m_recv_peer,
    input logic [CNT_W-1:0]      m_slice_count,
    input logic [NUM_W-1:0]      m_slice_number,
    input logic                  m_last
);

    // A taken word keeps the input closed on the next cycle while setup runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // A stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slice_number) && $stable(m_last))
        else $error("stalled result word changed");

    // Idle word is alone and carries no peers or count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_role == ROLE_IDLE) |->
            m_last && (m_send_peer == '0) && (m_recv_peer == '0) && (m_slice_count == '0))
        else $error("malformed idle word");

    // Last mark sits on the final slice position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_role != ROLE_IDLE) |->
            (m_last == (({1'b0, m_slice_number} + CNT_W'(1)) == m_slice_count)))
        else $error("last mark off the final slice");

endmodule

bind broadcast_step_slice_schedule_core bsss_checker u_bsss_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_role         (m_role),
    .m_send_peer    (m_send_peer),
    .m_recv_peer    (m_recv_peer),
    .m_slice_count  (m_slice_count),
    .m_slice_number (m_slice_number),
    .m_last         (m_last)
);
